FILE: rtl/cdbr_pkg.sv
`default_nettype none

package cdbr_pkg;

  localparam int DEF_KERNEL_SIZE  = 5;
  localparam int DEF_MAX_CHANNELS = 16;
  localparam int DEF_MAX_WIDTH    = 32;

  localparam int VAL_W      = 16;
  localparam int SUM_W      = 40;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int FRAC_SHIFT = 14;
  localparam int QW         = SUM_W - FRAC_SHIFT + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [4:0]       RST_IN_CHANNELS = 5'd1;
  localparam logic [5:0]       RST_MAP_WIDTH   = 6'd32;
  localparam logic [5:0]       RST_MAP_HEIGHT  = 6'd32;
  localparam logic [15:0]      RST_BIAS        = 16'd0;
  localparam logic             RST_USE_RELU    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_CHANNELS = 3'd0,
    CFG_MAP_WIDTH   = 3'd1,
    CFG_MAP_HEIGHT  = 3'd2,
    CFG_BIAS        = 3'd3,
    CFG_USE_RELU    = 3'd4
  } cdbr_cfg_idx_e;

  typedef enum logic {
    REQ_WEIGHT = 1'b0,
    REQ_PIXEL  = 1'b1
  } cdbr_req_e;

  typedef struct packed {
    logic              req_type;
    logic [3:0]        channel;
    logic [4:0]        row;
    logic [4:0]        col;
    logic signed [15:0] value;
  } cdbr_in_t;

  typedef struct packed {
    logic [4:0]         out_row;
    logic [4:0]         out_col;
    logic signed [15:0] out_value;
    logic               last;
  } cdbr_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TAP,
    ST_DRAIN,
    ST_EMIT
  } cdbr_state_e;

  typedef struct packed {
    logic capture;
    logic kwrite;
    logic tap_issue;
    logic load_out;
  } cdbr_cmd_t;

  typedef struct packed {
    logic is_weight;
    logic pix_ok;
    logic emit;
    logic pipe_busy;
    logic out_free;
  } cdbr_sts_t;

endpackage

`default_nettype wire

FILE: rtl/cdbr_ctrl.sv
`default_nettype none

module cdbr_ctrl import cdbr_pkg::*; #(
  parameter int KERNEL_SIZE = DEF_KERNEL_SIZE,
  localparam int KCW = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire cdbr_sts_t      sts_i,
  output cdbr_cmd_t           cmd_o,
  output logic [KCW-1:0]      tap_kr_o,
  output logic [KCW-1:0]      tap_kc_o
);

  localparam logic [KCW-1:0] TAP_MAX = KCW'(KERNEL_SIZE - 1);

  cdbr_state_e state_q, state_d;
  logic [KCW-1:0] kr_q, kr_d, kc_q, kc_d;
  logic last_tap;

  assign last_tap = (kr_q == TAP_MAX) && (kc_q == TAP_MAX);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (!sts_i.is_weight && sts_i.pix_ok) state_d = ST_TAP;
        else state_d = ST_IDLE;
      end
      ST_TAP: begin
        if (last_tap) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = sts_i.emit ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    kr_d       = kr_q;
    kc_d       = kc_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.kwrite = sts_i.is_weight;
        kr_d         = '0;
        kc_d         = '0;
      end
      ST_TAP: begin
        cmd_o.tap_issue = 1'b1;
        if (kc_q == TAP_MAX) begin
          kc_d = '0;
          kr_d = kr_q + 1'b1;
        end else begin
          kc_d = kc_q + 1'b1;
        end
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kr_q    <= '0;
      kc_q    <= '0;
    end else begin
      state_q <= state_d;
      kr_q    <= kr_d;
      kc_q    <= kc_d;
    end
  end

  assign tap_kr_o = kr_q;
  assign tap_kc_o = kc_q;

endmodule

`default_nettype wire

FILE: rtl/cdbr_dp.sv
`default_nettype none

module cdbr_dp import cdbr_pkg::*; #(
  parameter int KERNEL_SIZE  = DEF_KERNEL_SIZE,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  localparam int KCW = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire cdbr_in_t              in_data_i,
  input  wire cdbr_cmd_t             cmd_i,
  input  wire logic [KCW-1:0]        tap_kr_i,
  input  wire logic [KCW-1:0]        tap_kc_i,
  output cdbr_sts_t                  sts_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output cdbr_out_t                  out_data_o
);

  localparam int TAPS    = KERNEL_SIZE * KERNEL_SIZE;
  localparam int OUT_DIM = MAX_WIDTH - KERNEL_SIZE + 1;
  localparam int KDEPTH  = MAX_CHANNELS * TAPS;
  localparam int PDEPTH  = OUT_DIM * OUT_DIM;
  localparam int KAW     = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int PAW     = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int DIMW    = $clog2(MAX_WIDTH + 1);
  localparam int NCHW    = $clog2(MAX_CHANNELS + 1);
  localparam logic signed [QW-1:0] Q_MAX = QW'(32767);
  localparam logic signed [QW-1:0] Q_MIN = -QW'(32768);

  logic [4:0]              in_ch_q;
  logic [5:0]              map_w_q, map_h_q;
  logic signed [VAL_W-1:0] bias_q;
  logic                    relu_q;

  cdbr_in_t item_q;

  logic [NCHW-1:0] nch;
  logic [DIMW-1:0] w, h, oh, ow;
  logic            wt_ok, tap_ok;
  logic [4:0]      tap_orow, tap_ocol, emit_row, emit_col;
  logic [KAW-1:0]  kaddr_wr, kaddr_rd;
  logic [PAW-1:0]  paddr_rd;

  logic signed [VAL_W-1:0]  kmem [KDEPTH];
  logic [SUM_W-1:0]         pmem [PDEPTH];
  logic signed [VAL_W-1:0]  kw_q;
  logic [SUM_W-1:0]         ps_q;

  logic             a_valid_q, a_first_q, a_last_q;
  logic [PAW-1:0]   a_idx_q;
  logic             b_valid_q, b_first_q, b_last_q;
  logic [PAW-1:0]   b_idx_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0] b_ps_q, acc, last_acc_q;

  logic signed [QW-2:0] shifted;
  logic signed [QW-1:0] q_sum, q_act;
  logic signed [VAL_W-1:0] q_sat;

  logic      out_valid_q;
  cdbr_out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q <= RST_IN_CHANNELS;
      map_w_q <= RST_MAP_WIDTH;
      map_h_q <= RST_MAP_HEIGHT;
      bias_q  <= RST_BIAS;
      relu_q  <= RST_USE_RELU;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IN_CHANNELS: in_ch_q <= cfg_wdata_i[4:0];
        CFG_MAP_WIDTH:   map_w_q <= cfg_wdata_i[5:0];
        CFG_MAP_HEIGHT:  map_h_q <= cfg_wdata_i[5:0];
        CFG_BIAS:        bias_q  <= cfg_wdata_i;
        CFG_USE_RELU:    relu_q  <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
  end

  always_comb begin
    if (in_ch_q == '0) nch = NCHW'(1);
    else if (32'(in_ch_q) > MAX_CHANNELS) nch = NCHW'(MAX_CHANNELS);
    else nch = NCHW'(in_ch_q);

    if (32'(map_w_q) < KERNEL_SIZE) w = DIMW'(KERNEL_SIZE);
    else if (32'(map_w_q) > MAX_WIDTH) w = DIMW'(MAX_WIDTH);
    else w = DIMW'(map_w_q);

    if (32'(map_h_q) < KERNEL_SIZE) h = DIMW'(KERNEL_SIZE);
    else if (32'(map_h_q) > MAX_WIDTH) h = DIMW'(MAX_WIDTH);
    else h = DIMW'(map_h_q);
  end

  assign oh = h - DIMW'(KERNEL_SIZE - 1);
  assign ow = w - DIMW'(KERNEL_SIZE - 1);

  assign wt_ok = (32'(item_q.channel) < MAX_CHANNELS) && (32'(item_q.row) < KERNEL_SIZE)
              && (32'(item_q.col) < KERNEL_SIZE);

  assign sts_o.is_weight = (item_q.req_type == REQ_WEIGHT);
  assign sts_o.pix_ok    = (32'(item_q.channel) < 32'(nch)) && (32'(item_q.row) < 32'(h))
                        && (32'(item_q.col) < 32'(w));
  assign sts_o.emit      = (32'(item_q.channel) + 32'd1 == 32'(nch))
                        && (32'(item_q.row) >= KERNEL_SIZE - 1)
                        && (32'(item_q.col) >= KERNEL_SIZE - 1);
  assign sts_o.pipe_busy = a_valid_q || b_valid_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign tap_orow = item_q.row - 5'(tap_kr_i);
  assign tap_ocol = item_q.col - 5'(tap_kc_i);
  assign tap_ok   = (32'(item_q.row) >= 32'(tap_kr_i)) && (32'(tap_orow) < 32'(oh))
                 && (32'(item_q.col) >= 32'(tap_kc_i)) && (32'(tap_ocol) < 32'(ow));

  assign kaddr_wr = KAW'(32'(item_q.channel) * TAPS + 32'(item_q.row) * KERNEL_SIZE
                       + 32'(item_q.col));
  assign kaddr_rd = KAW'(32'(item_q.channel) * TAPS + 32'(tap_kr_i) * KERNEL_SIZE
                       + 32'(tap_kc_i));
  assign paddr_rd = PAW'(32'(tap_orow) * OUT_DIM + 32'(tap_ocol));

  always_ff @(posedge clk_i) begin
    if (cmd_i.kwrite && wt_ok) kmem[kaddr_wr] <= item_q.value;
    if (cmd_i.tap_issue) kw_q <= kmem[kaddr_rd];
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q) pmem[b_idx_q] <= acc;
    if (cmd_i.tap_issue) ps_q <= pmem[paddr_rd];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= cmd_i.tap_issue && tap_ok;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_first_q <= (item_q.channel == '0) && (tap_kr_i == '0) && (tap_kc_i == '0);
    a_last_q  <= (32'(tap_kr_i) == KERNEL_SIZE - 1) && (32'(tap_kc_i) == KERNEL_SIZE - 1);
    a_idx_q   <= paddr_rd;
    prod_q    <= item_q.value * kw_q;
    b_ps_q    <= ps_q;
    b_first_q <= a_first_q;
    b_last_q  <= a_last_q;
    b_idx_q   <= a_idx_q;
    if (b_valid_q && b_last_q) last_acc_q <= acc;
  end

  assign acc = b_first_q ? SUM_W'(prod_q) : b_ps_q + SUM_W'(prod_q);

  assign shifted = $signed(last_acc_q[SUM_W-1:FRAC_SHIFT]);
  assign q_sum   = QW'(shifted) + QW'(bias_q);

  always_comb begin
    q_act = q_sum;
    if (relu_q && q_sum < 0) q_act = '0;
    if (q_act > Q_MAX) q_sat = VAL_W'(Q_MAX);
    else if (q_act < Q_MIN) q_sat = VAL_W'(Q_MIN);
    else q_sat = q_act[VAL_W-1:0];
  end

  assign emit_row = item_q.row - 5'(KERNEL_SIZE - 1);
  assign emit_col = item_q.col - 5'(KERNEL_SIZE - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q.out_row   <= emit_row;
      out_data_q.out_col   <= emit_col;
      out_data_q.out_value <= q_sat;
      out_data_q.last      <= (32'(emit_row) + 32'd1 == 32'(oh))
                           && (32'(emit_col) + 32'd1 == 32'(ow));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/conv2d_valid_bias_relu.sv
`default_nettype none

// One output map of a convolution layer: weights (req_type 0) are loaded into the kernel
// memory first, then pixels (req_type 1) arrive channel by channel in raster order. Each
// pixel is multiplied by every kernel tap that lands on a valid output, and the 40-bit
// partial sums are updated in a single read/write memory, one tap per cycle through a
// three-stage read, multiply, accumulate pipe. A weight transaction passes through idle
// and decode only. A pixel inside the map then steps through every tap, waits in drain
// until its last taps have left the pipe and, when it completes an output, waits in emit
// while the output register is held by a stall; a pixel outside the map returns to idle
// after decode. The pixel on the last channel that completes an output produces one
// result: sum >> 14, plus bias, optional ReLU, saturated to 16 bits. A finished result
// waits in the output register while the next transaction is taken. Configure only while
// idle.
module conv2d_valid_bias_relu import cdbr_pkg::*; #(
  parameter int KERNEL_SIZE  = DEF_KERNEL_SIZE,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire cdbr_in_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output cdbr_out_t                  out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int KCW = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;

  cdbr_cmd_t      cmd;
  cdbr_sts_t      sts;
  logic [KCW-1:0] tap_kr, tap_kc;

  cdbr_ctrl #(
    .KERNEL_SIZE (KERNEL_SIZE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .tap_kr_o   (tap_kr),
    .tap_kc_o   (tap_kc)
  );

  cdbr_dp #(
    .KERNEL_SIZE  (KERNEL_SIZE),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_WIDTH    (MAX_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .tap_kr_i    (tap_kr),
    .tap_kc_i    (tap_kc),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("transaction accepted but block not busy next cycle");

  a_pipe_idle_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.pipe_busy |-> in_stall_o)
    else $error("accumulate pipe busy while input is open");

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || !out_stall_i))
    else $error("result loaded over a pending result");

  a_tap_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.tap_issue |-> !cmd.capture && !cmd.load_out && !cmd.kwrite)
    else $error("tap issued together with another command");

endmodule

`default_nettype wire
